// ===== hw/rtl/direct_mapped_writeback_tag_store_defines.svh =====
// Assertion macros shared by the tag store checkers.
// Included by the checker file; needs nothing else.
`ifndef DIRECT_MAPPED_WRITEBACK_TAG_STORE_DEFINES_SVH
`define DIRECT_MAPPED_WRITEBACK_TAG_STORE_DEFINES_SVH

// same-cycle implication, quiet while rst is high
`define DMWTS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, quiet while rst is high
`define DMWTS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/dmwts_pkg.sv =====
// Shared types and constants of the direct-mapped write-back tag store.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package dmwts_pkg;

   // stream payload widths (fields packed from bit 0, padded to bytes)
   localparam int CMD_BITS      = 2;
   localparam int FIELD_BITS    = 32;
   localparam int REQ_DATA_BITS = 40;
   localparam int RSP_DATA_BITS = 136;
   localparam int OP_BITS       = 2;

   // request command codes
   localparam logic [CMD_BITS-1:0] CMD_READ    = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_WRITE   = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_INSTALL = 2'd2;

   // decoded operation carried from front to back
   typedef enum logic [OP_BITS-1:0] {
      OP_READ,
      OP_WRITE,
      OP_INSTALL,
      OP_NONE
   } op_type;

   // back-end sequencer
   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_UPDATE
   } back_state_type;

endpackage

// ===== hw/rtl/dmwts_front.sv =====
// Front end: takes requests, splits the address into set and tag, decodes the command.
// Uses dmwts_pkg; feeds dmwts_queue.
`timescale 1ns / 1ps

module dmwts_front #(
   parameter int BLOCK_BYTES  = 64,
   parameter int SET_COUNT    = 256,
   parameter int ADDRESS_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              enable,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [dmwts_pkg::REQ_DATA_BITS-1:0] req_tdata,
   output logic                              push_valid,
   input  logic                              push_ready,
   output logic [dmwts_pkg::OP_BITS + ((((ADDRESS_BITS < 32) ? ADDRESS_BITS : 32)
                 - $clog2(BLOCK_BYTES) - $clog2(SET_COUNT)) < 1 ? 1 :
                 (((ADDRESS_BITS < 32) ? ADDRESS_BITS : 32)
                 - $clog2(BLOCK_BYTES) - $clog2(SET_COUNT))) + $clog2(SET_COUNT) - 1:0]
                                             push_data
);
   import dmwts_pkg::*;

   localparam int OFFSET_BITS  = $clog2(BLOCK_BYTES);
   localparam int INDEX_BITS   = $clog2(SET_COUNT);
   localparam int EFF_BITS     = (ADDRESS_BITS < 32) ? ADDRESS_BITS : 32;
   localparam int TAG_RAW_BITS = EFF_BITS - OFFSET_BITS - INDEX_BITS;
   localparam int TAG_BITS     = (TAG_RAW_BITS < 1) ? 1 : TAG_RAW_BITS;
   localparam int ENTRY_BITS   = OP_BITS + TAG_BITS + INDEX_BITS;
   localparam logic [FIELD_BITS-1:0] ADDR_MASK = (ADDRESS_BITS >= 32) ? 32'hFFFF_FFFF :
                                   32'((64'd1 << ADDRESS_BITS) - 64'd1);

   logic [CMD_BITS-1:0]   cmd;
   logic [FIELD_BITS-1:0] eff_addr;
   logic [FIELD_BITS-1:0] tag_wide;
   logic [INDEX_BITS-1:0] set_idx;
   logic [TAG_BITS-1:0]   tag;
   op_type                op;
   logic                  take;

   logic                  front_valid_ff, front_valid_in;
   logic [ENTRY_BITS-1:0] front_entry_ff, front_entry_in;

   // address split and command decode
   always_comb begin
      cmd      = req_tdata[CMD_BITS-1:0];
      eff_addr = req_tdata[CMD_BITS +: FIELD_BITS] & ADDR_MASK;
      set_idx  = eff_addr[OFFSET_BITS +: INDEX_BITS];
      tag_wide = eff_addr >> (OFFSET_BITS + INDEX_BITS);
      tag      = tag_wide[TAG_BITS-1:0];
      case (cmd)
         CMD_READ:    op = OP_READ;
         CMD_WRITE:   op = OP_WRITE;
         CMD_INSTALL: op = OP_INSTALL;
         default:     op = OP_NONE;
      endcase
   end

   // one holding stage in front of the queue
   assign req_tready = enable && (!front_valid_ff || push_ready);
   assign take       = req_tvalid && req_tready;
   assign push_valid = front_valid_ff;
   assign push_data  = front_entry_ff;

   always_comb begin
      front_valid_in = front_valid_ff;
      front_entry_in = front_entry_ff;
      if (take) begin
         front_valid_in = 1'b1;
         front_entry_in = {op, tag, set_idx};
      end else if (push_ready) begin
         front_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      front_entry_ff <= front_entry_in;
   end

endmodule

// ===== hw/rtl/dmwts_queue.sv =====
// Two-entry queue between the front end and the back end.
// Uses dmwts_pkg for nothing but house style; width comes from DATA_BITS.
`timescale 1ns / 1ps

module dmwts_queue #(
   parameter int DATA_BITS = 28
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  logic [DATA_BITS-1:0] push_data,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output logic [DATA_BITS-1:0] pop_data
);
   import dmwts_pkg::*;

   logic [DATA_BITS-1:0] slot_ff [2];
   logic                 wr_ptr_ff, wr_ptr_in;
   logic                 rd_ptr_ff, rd_ptr_in;
   logic [1:0]           count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/dmwts_back.sv =====
// Back end: clears the flag memory after reset, then reads and updates the tag and
// flag memories one request at a time and holds the response. Uses dmwts_pkg.
`timescale 1ns / 1ps

module dmwts_back #(
   parameter int BLOCK_BYTES  = 64,
   parameter int SET_COUNT    = 256,
   parameter int ADDRESS_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   output logic                                ready_for_work,
   input  logic                                pop_valid,
   output logic                                pop_ready,
   input  logic [dmwts_pkg::OP_BITS + ((((ADDRESS_BITS < 32) ? ADDRESS_BITS : 32)
                 - $clog2(BLOCK_BYTES) - $clog2(SET_COUNT)) < 1 ? 1 :
                 (((ADDRESS_BITS < 32) ? ADDRESS_BITS : 32)
                 - $clog2(BLOCK_BYTES) - $clog2(SET_COUNT))) + $clog2(SET_COUNT) - 1:0]
                                               pop_data,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [dmwts_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);
   import dmwts_pkg::*;

   localparam int OFFSET_BITS  = $clog2(BLOCK_BYTES);
   localparam int INDEX_BITS   = $clog2(SET_COUNT);
   localparam int EFF_BITS     = (ADDRESS_BITS < 32) ? ADDRESS_BITS : 32;
   localparam int TAG_RAW_BITS = EFF_BITS - OFFSET_BITS - INDEX_BITS;
   localparam int TAG_BITS     = (TAG_RAW_BITS < 1) ? 1 : TAG_RAW_BITS;
   localparam int ENTRY_BITS   = OP_BITS + TAG_BITS + INDEX_BITS;
   localparam int PAD_BITS     = RSP_DATA_BITS - 2 - 4 * FIELD_BITS;
   localparam logic [INDEX_BITS-1:0] LAST_SET = INDEX_BITS'(SET_COUNT - 1);

   // memories: flags are {valid, dirty}; tags are never cleared
   logic [1:0]          flag_mem [SET_COUNT];
   logic [TAG_BITS-1:0] tag_mem  [SET_COUNT];

   back_state_type        state_ff, state_in;
   logic [INDEX_BITS-1:0] clr_ff, clr_in;
   logic [ENTRY_BITS-1:0] cur_ff, cur_in;
   logic [1:0]            rd_flags_ff;
   logic [TAG_BITS-1:0]   rd_tag_ff;

   logic [FIELD_BITS-1:0] hits_ff, hits_in;
   logic [FIELD_BITS-1:0] misses_ff, misses_in;
   logic [FIELD_BITS-1:0] flushes_ff, flushes_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic                  rsp_wbv_ff, rsp_wbv_in;
   logic [FIELD_BITS-1:0] rsp_wba_ff, rsp_wba_in;

   // memory port controls
   logic                  rd_en;
   logic [INDEX_BITS-1:0] rd_addr;
   logic                  flag_we;
   logic [INDEX_BITS-1:0] flag_waddr;
   logic [1:0]            flag_wdata;
   logic                  tag_we;

   // decoded current request
   op_type                cur_op;
   logic [TAG_BITS-1:0]   cur_tag;
   logic [INDEX_BITS-1:0] cur_set;
   logic                  is_lookup;
   logic                  lk_hit;
   logic                  lk_miss;
   logic                  wb_needed;
   logic                  slot_free;
   logic [63:0]           wb_wide;

   always_comb begin
      cur_op    = op_type'(cur_ff[ENTRY_BITS-1 -: OP_BITS]);
      cur_tag   = cur_ff[INDEX_BITS +: TAG_BITS];
      cur_set   = cur_ff[INDEX_BITS-1:0];
      is_lookup = (cur_op == OP_READ) || (cur_op == OP_WRITE);
      lk_hit    = is_lookup && rd_flags_ff[1] && (rd_tag_ff == cur_tag);
      lk_miss   = is_lookup && !lk_hit;
      wb_needed = lk_miss && rd_flags_ff[0];
      wb_wide   = (64'(rd_tag_ff) << (OFFSET_BITS + INDEX_BITS))
                | (64'(cur_set) << OFFSET_BITS);
      slot_free = !rsp_valid_ff || rsp_tready;
   end

   // sequencer: clearing pass, read, update
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      cur_in       = cur_ff;
      pop_ready    = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = pop_data[INDEX_BITS-1:0];
      flag_we      = 1'b0;
      flag_waddr   = cur_set;
      flag_wdata   = rd_flags_ff;
      tag_we       = 1'b0;
      hits_in      = hits_ff;
      misses_in    = misses_ff;
      flushes_in   = flushes_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_hit_in   = rsp_hit_ff;
      rsp_wbv_in   = rsp_wbv_ff;
      rsp_wba_in   = rsp_wba_ff;
      case (state_ff)
         BK_CLEAR: begin
            flag_we    = 1'b1;
            flag_waddr = clr_ff;
            flag_wdata = 2'b00;
            clr_in     = clr_ff + INDEX_BITS'(1);
            if (clr_ff == LAST_SET) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               rd_en    = 1'b1;
               cur_in   = pop_data;
               state_in = BK_UPDATE;
            end
         end
         BK_UPDATE: begin
            if (slot_free) begin
               state_in = BK_IDLE;
               flag_we  = (cur_op != OP_NONE);
               tag_we   = (cur_op == OP_INSTALL);
               if (lk_hit) begin
                  flag_wdata = {1'b1, rd_flags_ff[0] || (cur_op == OP_WRITE)};
                  hits_in    = hits_ff + 32'd1;
               end else if (lk_miss) begin
                  flag_wdata = {1'b0, rd_flags_ff[0]};
                  misses_in  = misses_ff + 32'd1;
               end else begin
                  flag_wdata = 2'b10;
               end
               if (wb_needed) begin
                  flushes_in = flushes_ff + 32'd1;
               end
               rsp_valid_in = 1'b1;
               rsp_hit_in   = lk_hit;
               rsp_wbv_in   = wb_needed;
               rsp_wba_in   = wb_needed ? wb_wide[FIELD_BITS-1:0] : '0;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         clr_ff       <= '0;
         hits_ff      <= '0;
         misses_ff    <= '0;
         flushes_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         hits_ff      <= hits_in;
         misses_ff    <= misses_in;
         flushes_ff   <= flushes_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      rsp_hit_ff <= rsp_hit_in;
      rsp_wbv_ff <= rsp_wbv_in;
      rsp_wba_ff <= rsp_wba_in;
   end

   // flag memory, registered read
   always_ff @(posedge clock) begin
      if (flag_we) begin
         flag_mem[flag_waddr] <= flag_wdata;
      end
      if (rd_en) begin
         rd_flags_ff <= flag_mem[rd_addr];
      end
   end

   // tag memory, registered read
   always_ff @(posedge clock) begin
      if (tag_we) begin
         tag_mem[cur_set] <= cur_tag;
      end
      if (rd_en) begin
         rd_tag_ff <= tag_mem[rd_addr];
      end
   end

   assign ready_for_work = (state_ff != BK_CLEAR);
   assign rsp_tvalid     = rsp_valid_ff;
   assign rsp_tdata      = {{PAD_BITS{1'b0}}, flushes_ff, misses_ff, hits_ff,
                            rsp_wba_ff, rsp_wbv_ff, rsp_hit_ff};

endmodule

// ===== hw/rtl/direct_mapped_writeback_tag_store.sv =====
// Tag store of a direct-mapped write-back cache. Each request (read lookup, write lookup or
// install) returns one response: hit, writeback flag and block address, and the wrapping hit,
// miss and flush counters. The back end reads the set's tag and flags in its idle state and
// compares and writes back in its update state, taking no new request while it updates. An
// accepted request passes the front end's holding register, a queue slot and the back end's
// read registers on its way to the response. A stalled response holds the back end, then the
// queue, then the request side. After reset the flag memory is swept clear, one set a cycle,
// and no request is taken meanwhile. BLOCK_BYTES and SET_COUNT must be powers of two.
`timescale 1ns / 1ps

module direct_mapped_writeback_tag_store #(
   parameter int BLOCK_BYTES  = 64,
   parameter int SET_COUNT    = 256,
   parameter int ADDRESS_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: cmd[1:0], address[33:2], zero pad[39:34]
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [dmwts_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // rsp_tdata: hit[0], writeback_valid[1], writeback_address[33:2], hit_count[65:34],
   //            miss_count[97:66], flush_count[129:98], zero pad[135:130]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [dmwts_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);
   import dmwts_pkg::*;

   localparam int OFFSET_BITS  = $clog2(BLOCK_BYTES);
   localparam int INDEX_BITS   = $clog2(SET_COUNT);
   localparam int EFF_BITS     = (ADDRESS_BITS < 32) ? ADDRESS_BITS : 32;
   localparam int TAG_RAW_BITS = EFF_BITS - OFFSET_BITS - INDEX_BITS;
   localparam int TAG_BITS     = (TAG_RAW_BITS < 1) ? 1 : TAG_RAW_BITS;
   localparam int ENTRY_BITS   = OP_BITS + TAG_BITS + INDEX_BITS;

   logic                  work_ready;
   logic                  push_valid;
   logic                  push_ready;
   logic [ENTRY_BITS-1:0] push_data;
   logic                  pop_valid;
   logic                  pop_ready;
   logic [ENTRY_BITS-1:0] pop_data;

   // request decode
   dmwts_front #(
      .BLOCK_BYTES  (BLOCK_BYTES),
      .SET_COUNT    (SET_COUNT),
      .ADDRESS_BITS (ADDRESS_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .enable     (work_ready),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // decoupling queue
   dmwts_queue #(
      .DATA_BITS (ENTRY_BITS)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // memory update and response
   dmwts_back #(
      .BLOCK_BYTES  (BLOCK_BYTES),
      .SET_COUNT    (SET_COUNT),
      .ADDRESS_BITS (ADDRESS_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .ready_for_work (work_ready),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_data       (pop_data),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata)
   );

endmodule

// ===== hw/rtl/dmwts_checker.sv =====
// Port-level checks of the tag store, bound to the top level.
// Uses dmwts_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "direct_mapped_writeback_tag_store_defines.svh"

module dmwts_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [dmwts_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [dmwts_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);
   import dmwts_pkg::*;

   // a waiting request holds
   `DMWTS_ASSERT_NEXT(a_req_hold, clock, reset, req_tvalid && !req_tready, req_tvalid && $stable(req_tdata), "request changed while waiting")

   // a stalled response holds
   `DMWTS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "response changed while stalled")

   // a hit never evicts
   `DMWTS_ASSERT_NOW(a_hit_no_wb, clock, reset, rsp_tvalid, !(rsp_tdata[0] && rsp_tdata[1]), "hit and writeback in one response")

   // no writeback means a zero writeback address
   `DMWTS_ASSERT_NOW(a_wb_addr_zero, clock, reset, rsp_tvalid && !rsp_tdata[1], rsp_tdata[33:2] == 32'd0, "writeback address set without writeback")

   // reset drops the response and blocks requests
   `DMWTS_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_tvalid && !req_tready, "response or ready right after reset")

endmodule

bind direct_mapped_writeback_tag_store dmwts_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
